[rtl/bpca_pkg.sv]
// Shared constants and register codes for the barometric pressure compensation block.
package bpca_pkg;

  localparam int ADC_W      = 10;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 24;
  localparam int VALUE_W    = 19;
  localparam int SUM_W      = 26;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int A0_W  = 16;
  localparam int B1_W  = 16;
  localparam int B2_W  = 16;
  localparam int C12_W = 14;
  localparam int AVG_W = 8;

  localparam int CAL_FRAC = 22;
  localparam int A0_SHIFT = CAL_FRAC - 3;
  localparam int B1_SHIFT = CAL_FRAC - 13;
  localparam int B2_SHIFT = CAL_FRAC - 14;

  localparam int PRES_BASE  = 50;
  localparam int SPAN_MUL   = 115 - 50;
  localparam int ADC_FULL   = 1023;
  localparam int LIMIT_LO   = 49;
  localparam int LIMIT_HI   = 116;
  localparam longint CAL_DEN = longint'(ADC_FULL) <<< CAL_FRAC;

  typedef enum logic [2:0] {
    REG_A0  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_C12 = 3'd3,
    REG_AVG = 3'd4
  } reg_idx_t;

endpackage

[rtl/bpca_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module bpca_serial_div #(
  parameter int N = 29,
  parameter int M = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic [N-1:0] quotient,
  output logic         done
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     dq;
  logic [M-1:0]     rem;
  logic [M-1:0]     dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [M:0]       partial;
  logic [M:0]       diff;
  logic             fits;

  assign partial  = {rem, dq[N-1]};
  assign diff     = partial - {1'b0, dvs};
  assign fits     = !diff[M];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == CNT_W'(1));
      if (start) begin
        dq    <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        count <= CNT_W'(N);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? diff[M-1:0] : partial[M-1:0];
        dq    <= {dq[N-2:0], fits};
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/baro_pressure_compensate_average_top.sv]
// Top level: bit-serial pressure compensation, range check and running average.
// An out-of-range sample gives an error result without using the divider; an in-range
// sample is divided once to scale it, and a sample that completes an average once more.
// A new sample is taken only when the block is idle, after the previous one is done;
// the shift-add multiplier and the one-bit-per-cycle divider set the pace. A stalled
// result holds off the next one.
// Reset (rst, synchronous, active high) clears coefficients, count to 1, sum and result valid.
module baro_pressure_compensate_average_top #(
  parameter int MAX_SAMPLES = 128,
  parameter int FRAC_BITS   = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] pressure_adc, [19:10] temperature_adc, [23:20] zero
  input  logic [bpca_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [18:0] pressure_value, [23:19] zero
  output logic [bpca_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] status
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bpca_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bpca_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bpca_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int ADC_W  = bpca_pkg::ADC_W;
  localparam int TW     = 46;
  localparam int KW     = 26;
  localparam int STEP_W = $clog2(ADC_W);
  localparam int SHR    = bpca_pkg::CAL_FRAC - FRAC_BITS;
  localparam int VW     = FRAC_BITS + 7;
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int EW     = (CW > bpca_pkg::AVG_W) ? CW : bpca_pkg::AVG_W;
  localparam int SUM_W  = bpca_pkg::SUM_W;
  localparam int SAT_W  = ((SUM_W > VW) ? SUM_W : VW) + 1;
  localparam int DIV_N  = (FRAC_BITS + 17 > SUM_W) ? FRAC_BITS + 17 : SUM_W;
  localparam int DIV_M  = (CW > ADC_W) ? CW : ADC_W;

  localparam logic signed [TW-1:0] OFFSET =
    TW'(longint'(bpca_pkg::PRES_BASE) * bpca_pkg::CAL_DEN);
  localparam logic signed [TW-1:0] LIM_LO =
    TW'(longint'(bpca_pkg::LIMIT_LO) * bpca_pkg::CAL_DEN);
  localparam logic signed [TW-1:0] LIM_HI =
    TW'(longint'(bpca_pkg::LIMIT_HI) * bpca_pkg::CAL_DEN);
  localparam int SPAN_SHIFT = $clog2(bpca_pkg::SPAN_MUL) - 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_MUL_P,
    ST_SCALE,
    ST_CHECK,
    ST_DIV_P,
    ST_ACCUM,
    ST_DIV_M,
    ST_OUT
  } state_t;

  state_t state;

  logic signed [bpca_pkg::A0_W-1:0]  coef_a0;
  logic signed [bpca_pkg::B1_W-1:0]  coef_b1;
  logic signed [bpca_pkg::B2_W-1:0]  coef_b2;
  logic signed [bpca_pkg::C12_W-1:0] coef_c12;
  logic [bpca_pkg::AVG_W-1:0]        average_count;

  logic [STEP_W-1:0]       step;
  logic [ADC_W-1:0]        p_sh;
  logic [ADC_W-1:0]        t_sh;
  logic signed [KW-1:0]    mc;
  logic signed [TW-1:0]    mk;
  logic signed [TW-1:0]    mb;
  logic signed [TW-1:0]    acc;
  logic signed [TW-1:0]    acc_t_next;
  logic signed [TW-1:0]    acc_p_next;
  logic [TW-1:0]           acc_u;
  logic [VW-1:0]           value;
  logic [SUM_W-1:0]        pressure_sum;
  logic [CW-1:0]           samples_taken;
  logic [SAT_W-1:0]        sum_add;
  logic [SUM_W-1:0]        sum_next;
  logic [CW-1:0]           taken_next;
  logic [EW-1:0]           eff_count;
  logic                    last_step;
  logic                    in_range;
  logic                    avg_done;
  logic                    div_go;

  logic                    div_start;
  logic [DIV_N-1:0]        div_dividend;
  logic [DIV_M-1:0]        div_divisor;
  logic [DIV_N-1:0]        div_quot;
  logic                    div_done;

  logic [bpca_pkg::VALUE_W-1:0] res_value;
  logic                         res_status;
  logic [bpca_pkg::VALUE_W-1:0] m_value;
  logic                         m_status;
  logic                         m_valid;

  logic                         cfg_write;
  bpca_pkg::reg_idx_t           cfg_idx;

  bpca_serial_div #(
    .N(DIV_N),
    .M(DIV_M)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = bpca_pkg::M_TDATA_W'(m_value);
  assign m_axis_tuser  = m_status;
  assign pready        = 1'b1;

  assign last_step  = (step == STEP_W'(ADC_W - 1));
  assign acc_t_next = acc + (t_sh[0] ? TW'(mc) : TW'(0));
  assign acc_p_next = acc + (p_sh[0] ? mk : TW'(0)) + (t_sh[0] ? mb : TW'(0));
  assign acc_u      = acc;

  assign sum_add    = SAT_W'(pressure_sum) + SAT_W'(value);
  assign sum_next   = (sum_add[SAT_W-1:SUM_W] != '0) ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign taken_next = samples_taken + CW'(1);

  assign in_range = !(acc < LIM_LO || acc > LIM_HI);
  assign avg_done = (EW'(taken_next) >= eff_count);
  assign div_go   = ((state == ST_CHECK) && in_range) || ((state == ST_ACCUM) && avg_done);

  always_comb begin
    if (average_count == '0) begin
      eff_count = EW'(1);
    end else if (EW'(average_count) > EW'(MAX_SAMPLES)) begin
      eff_count = EW'(MAX_SAMPLES);
    end else begin
      eff_count = EW'(average_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_valid       <= 1'b0;
      div_start     <= 1'b0;
      pressure_sum  <= '0;
      samples_taken <= '0;
      step          <= '0;
    end else begin
      div_start <= div_go;
      if (m_valid && m_axis_tready && (state != ST_OUT)) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            p_sh  <= s_axis_tdata[ADC_W-1:0];
            t_sh  <= s_axis_tdata[2*ADC_W-1:ADC_W];
            acc   <= TW'(coef_b1) <<< bpca_pkg::B1_SHIFT;
            mc    <= KW'(coef_c12);
            step  <= '0;
            state <= ST_MUL_T;
          end
        end
        ST_MUL_T: begin
          mc   <= mc <<< 1;
          t_sh <= {t_sh[0], t_sh[ADC_W-1:1]};
          step <= last_step ? '0 : step + STEP_W'(1);
          if (last_step) begin
            mk    <= acc_t_next;
            mb    <= TW'(coef_b2) <<< bpca_pkg::B2_SHIFT;
            acc   <= TW'(coef_a0) <<< bpca_pkg::A0_SHIFT;
            state <= ST_MUL_P;
          end else begin
            acc <= acc_t_next;
          end
        end
        ST_MUL_P: begin
          acc  <= acc_p_next;
          mk   <= mk <<< 1;
          mb   <= mb <<< 1;
          p_sh <= p_sh >> 1;
          t_sh <= t_sh >> 1;
          step <= step + STEP_W'(1);
          if (last_step) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          acc   <= OFFSET + (acc <<< SPAN_SHIFT) + acc;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!in_range) begin
            res_value     <= '0;
            res_status    <= 1'b1;
            pressure_sum  <= '0;
            samples_taken <= '0;
            state         <= ST_OUT;
          end else begin
            div_dividend <= DIV_N'(acc_u >> SHR);
            div_divisor  <= DIV_M'(bpca_pkg::ADC_FULL);
            state        <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (div_done) begin
            value <= div_quot[VW-1:0];
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          pressure_sum  <= sum_next;
          samples_taken <= taken_next;
          if (avg_done) begin
            div_dividend <= DIV_N'(sum_next);
            div_divisor  <= DIV_M'(taken_next);
            state        <= ST_DIV_M;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV_M: begin
          if (div_done) begin
            res_value     <= bpca_pkg::VALUE_W'(div_quot);
            res_status    <= 1'b0;
            pressure_sum  <= '0;
            samples_taken <= '0;
            state         <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid || m_axis_tready) begin
            m_value  <= res_value;
            m_status <= res_status;
            m_valid  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = bpca_pkg::reg_idx_t'(paddr[bpca_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0       <= '0;
      coef_b1       <= '0;
      coef_b2       <= '0;
      coef_c12      <= '0;
      average_count <= bpca_pkg::AVG_W'(1);
    end else if (cfg_write) begin
      case (cfg_idx)
        bpca_pkg::REG_A0:  coef_a0       <= pwdata[bpca_pkg::A0_W-1:0];
        bpca_pkg::REG_B1:  coef_b1       <= pwdata[bpca_pkg::B1_W-1:0];
        bpca_pkg::REG_B2:  coef_b2       <= pwdata[bpca_pkg::B2_W-1:0];
        bpca_pkg::REG_C12: coef_c12      <= pwdata[bpca_pkg::C12_W-1:0];
        bpca_pkg::REG_AVG: average_count <= pwdata[bpca_pkg::AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bpca_pkg::REG_A0:  prdata = bpca_pkg::CFG_DATA_W'(unsigned'(coef_a0));
      bpca_pkg::REG_B1:  prdata = bpca_pkg::CFG_DATA_W'(unsigned'(coef_b1));
      bpca_pkg::REG_B2:  prdata = bpca_pkg::CFG_DATA_W'(unsigned'(coef_b2));
      bpca_pkg::REG_C12: prdata = bpca_pkg::CFG_DATA_W'(unsigned'(coef_c12));
      bpca_pkg::REG_AVG: prdata = bpca_pkg::CFG_DATA_W'(average_count);
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/bpca_checker.sv]
// Port-level checker for the pressure compensation block, bound to the top level.
module bpca_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bpca_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result carries nonzero pressure");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample taken while previous sample in work");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind baro_pressure_compensate_average_top bpca_checker u_bpca_checker (.*);

[test/pressure_average_checker.sv]
// Checker for the pressure compensation block: predicts each reading and compares transfers.
`timescale 1ns / 1ps
module pressure_average_checker
  import bpca_pkg::*;
#(
  parameter int MAX_SAMPLES = 128,
  parameter int FRAC_BITS   = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } reading_t;

  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
  localparam longint SCALE_DEN = longint'(ADC_FULL) <<< CAL_FRAC;
  localparam longint VALUE_DIV = longint'(ADC_FULL) <<< (CAL_FRAC - FRAC_BITS);

  logic signed [A0_W-1:0]  a0_coef;
  logic signed [B1_W-1:0]  b1_coef;
  logic signed [B2_W-1:0]  b2_coef;
  logic signed [C12_W-1:0] c12_coef;
  logic [AVG_W-1:0]        avg_count;

  longint unsigned sum_acc;
  int              taken;
  reading_t        expected_readings[$];
  int              fail_count = 0;

  function automatic void predict_reading(input logic [ADC_W-1:0] p_raw,
                                          input logic [ADC_W-1:0] t_raw);
    longint   p;
    longint   t;
    longint   poly;
    longint   total;
    int       eff_count;
    reading_t r;
    p = longint'(p_raw);
    t = longint'(t_raw);
    poly = (longint'(a0_coef) <<< (CAL_FRAC - 3))
         + ((longint'(b1_coef) * p) <<< (CAL_FRAC - 13))
         + longint'(c12_coef) * t * p
         + ((longint'(b2_coef) * t) <<< (CAL_FRAC - 14));
    total = PRES_BASE * SCALE_DEN + SPAN_MUL * poly;
    if (total < LIMIT_LO * SCALE_DEN || total > LIMIT_HI * SCALE_DEN) begin
      r.value = '0;
      r.status = 1'b1;
      expected_readings.push_back(r);
      sum_acc = 0;
      taken = 0;
      return;
    end
    sum_acc = sum_acc + longint'(total / VALUE_DIV);
    if (sum_acc > SUM_LIMIT)
      sum_acc = SUM_LIMIT;
    taken++;
    eff_count = int'(avg_count);
    if (eff_count == 0)
      eff_count = 1;
    if (eff_count > MAX_SAMPLES)
      eff_count = MAX_SAMPLES;
    if (taken < eff_count)
      return;
    r.value = VALUE_W'(sum_acc / longint'(taken));
    r.status = 1'b0;
    expected_readings.push_back(r);
    sum_acc = 0;
    taken = 0;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      a0_coef = '0;
      b1_coef = '0;
      b2_coef = '0;
      c12_coef = '0;
      avg_count = AVG_W'(1);
      sum_acc = 0;
      taken = 0;
      expected_readings.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[VALUE_W-1:0];
        got.status = m_axis_tuser;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual value %0d status %0d",
                   $time, got.value, got.status);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: pressure_value expected %0d actual %0d",
                     $time, want.value, got.value);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_A0:  a0_coef = pwdata[A0_W-1:0];
          REG_B1:  b1_coef = pwdata[B1_W-1:0];
          REG_B2:  b2_coef = pwdata[B2_W-1:0];
          REG_C12: c12_coef = pwdata[C12_W-1:0];
          REG_AVG: avg_count = pwdata[AVG_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_reading(s_axis_tdata[ADC_W-1:0], s_axis_tdata[2*ADC_W-1:ADC_W]);
    end
    failures <= fail_count;
    pending <= expected_readings.size();
  end

endmodule

[test/baro_pressure_compensate_average_top_test.sv]
// Testbench top: drives samples and register writes into the pressure block and gives the verdict.
`timescale 1ns / 1ps
module baro_pressure_compensate_average_top_test;
  import bpca_pkg::*;

  localparam int ITEM_TARGET   = 1050;
  localparam int SETTLE_CYCLES = 128;
  localparam int LONG_HOLD     = 800;
  localparam int STUCK_LIMIT   = 5000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [9:0] pressure_adc, [19:10] temperature_adc, [23:20] zero
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [18:0] pressure_value, [23:19] zero
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // [0] status
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int failures;
  int pending;
  int items_sent = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int stuck_cycles = 0;

  baro_pressure_compensate_average_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pressure_average_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .failures      (failures),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: long hold on request, otherwise a stall pattern that changes mode
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int a0, input int b1, input int b2, input int c12,
                           input int count);
    write_reg(REG_A0, a0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_C12, c12);
    write_reg(REG_AVG, count);
  endtask

  task automatic send_sample(input logic [ADC_W-1:0] p, input logic [ADC_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0)
        gap = $urandom_range(1, 100);
      else if ($urandom_range(0, 1) == 0)
        gap = 0;
      else
        gap = $urandom_range(1, 3);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, t, p};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // drain the block before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic calm_coefs(input int count);
    configure(-int'($urandom_range(160, 320)), $urandom_range(8192, 9011),
              int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 100)) - 50, count);
  endtask

  // calm coefficients keep mid-range pressure readings valid; the wide draws hit the limits
  task automatic run_samples(input int n, input bit calm);
    for (int i = 0; i < n && items_sent < ITEM_TARGET; i++) begin
      if (!calm || $urandom_range(0, 11) == 0)
        send_sample($urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        send_sample($urandom_range(64, 900), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    int phase;
    int pick;
    int count;
    int eff;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: every sample reads exactly 50 kPa
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'h2AA, 10'h155);
    send_sample(10'h155, 10'h2AA);
    settle();

    // fixed slope: both ends of the pressure range fall out of limits
    configure(-240, 8602, 0, 0, 1);
    send_sample(10'd0, 10'd512);
    send_sample(10'd1023, 10'd512);
    send_sample(10'd500, 10'd0);
    send_sample(10'd500, 10'd1023);
    settle();

    // count of zero behaves as one
    write_reg(REG_AVG, 0);
    send_sample(10'd300, 10'd100);
    send_sample(10'd800, 10'd900);
    settle();

    // out-of-range sample drops a partial average
    write_reg(REG_AVG, 4);
    send_sample(10'd200, 10'd10);
    send_sample(10'd400, 10'd20);
    send_sample(10'd600, 10'd30);
    send_sample(10'd0, 10'd40);
    send_sample(10'd100, 10'd50);
    send_sample(10'd700, 10'd60);
    send_sample(10'd900, 10'd70);
    send_sample(10'd450, 10'd80);
    settle();

    // count lowered below the samples already taken
    write_reg(REG_AVG, 8);
    send_sample(10'd150, 10'd1);
    send_sample(10'd250, 10'd2);
    send_sample(10'd350, 10'd3);
    send_sample(10'd450, 10'd4);
    send_sample(10'd550, 10'd5);
    settle();
    write_reg(REG_AVG, 2);
    send_sample(10'd650, 10'd6);
    settle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin
          configure(32767, 32767, 32767, 8191, 1);
          run_samples(15, 1'b0);
        end
        1: begin
          configure(-32768, -32768, -32768, -8192, 128);
          run_samples(15, 1'b0);
        end
        2: begin
          configure(0, 0, 0, 0, 255);
          run_samples(140, 1'b0);
        end
        3: begin
          calm_coefs(1);
          hold_requests++;
          run_samples(60, 1'b1);
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 2) begin
            configure(int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 16383)) - 8192, $urandom_range(1, 3));
            run_samples(30, 1'b0);
          end else begin
            pick = $urandom_range(0, 19);
            if (pick < 6)
              count = 1;
            else if (pick < 12)
              count = $urandom_range(2, 8);
            else if (pick < 17)
              count = $urandom_range(9, 32);
            else if (pick == 17)
              count = 0;
            else if (pick == 18)
              count = 128;
            else
              count = $urandom_range(129, 255);
            eff = (count == 0) ? 1 : ((count > 128) ? 128 : count);
            calm_coefs(count);
            run_samples($urandom_range(2 * eff, 3 * eff) + 5, 1'b1);
          end
        end
      endcase
      settle();
      phase++;
    end

    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[baro_pressure_compensate_average_top.f]
rtl/bpca_pkg.sv
rtl/bpca_serial_div.sv
rtl/baro_pressure_compensate_average_top.sv
rtl/bpca_checker.sv
test/pressure_average_checker.sv
test/baro_pressure_compensate_average_top_test.sv
